### rtl/core/sha1_pkg.sv
// Shared types and constants for the SHA-1 digest unit.
package sha1_pkg;

   // Standard initial chaining values H0..H4
   localparam logic [31:0] INIT_H0 = 32'h6745_2301;
   localparam logic [31:0] INIT_H1 = 32'hEFCD_AB89;
   localparam logic [31:0] INIT_H2 = 32'h98BA_DCFE;
   localparam logic [31:0] INIT_H3 = 32'h1032_5476;
   localparam logic [31:0] INIT_H4 = 32'hC3D2_E1F0;

   // Round constants, one per group of twenty rounds
   localparam logic [31:0] K_GRP0 = 32'h5A82_7999;
   localparam logic [31:0] K_GRP1 = 32'h6ED9_EBA1;
   localparam logic [31:0] K_GRP2 = 32'h8F1B_BCDC;
   localparam logic [31:0] K_GRP3 = 32'hCA62_C1D6;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [5:0] LAST_SLOT  = 6'd63;
   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [2:0] LAST_WORD  = 3'd4;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_OUT
   } state_type;

   // Controls for the block buffer / message schedule
   typedef struct packed {
      logic       push;
      logic [7:0] push_byte;
      logic       step;
   } sched_ctl_type;

   // Controls for the shared round datapath
   typedef struct packed {
      logic       load;
      logic       step;
      logic [6:0] round;
      logic       fold;
      logic       reinit;
      logic [2:0] word_sel;
   } round_ctl_type;

endpackage

### rtl/core/sha1_msg_sched.sv
// Block buffer and rolling 16-word message schedule.
module sha1_msg_sched
   import sha1_pkg::*;
(
   input  logic          clock,
   input  sched_ctl_type ctl,
   output logic [31:0]   w_cur
);

   logic [511:0] win_ff;
   logic [511:0] win_in;
   logic [31:0]  w_mix;
   logic [31:0]  w_new;

   // word j of the window sits at bits 511-32j downward; word 0 is W[t]
   assign w_cur = win_ff[511:480];
   assign w_mix = win_ff[95:64] ^ win_ff[255:224] ^ win_ff[447:416] ^ win_ff[511:480];
   assign w_new = {w_mix[30:0], w_mix[31]};

   // bytes shift in big-endian; rounds shift out one word and append the next
   always_comb begin
      win_in = win_ff;
      if (ctl.push) begin
         win_in = {win_ff[503:0], ctl.push_byte};
      end else if (ctl.step) begin
         win_in = {win_ff[479:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

### rtl/core/sha1_round_core.sv
// Shared SHA-1 round datapath with the five chaining words.
module sha1_round_core
   import sha1_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  round_ctl_type ctl,
   input  logic [31:0]   w_cur,
   output logic [31:0]   digest_word
);

   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] t_sum;

   // round function and constant by group
   always_comb begin
      if (ctl.round < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K_GRP0;
      end else if (ctl.round < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_GRP1;
      end else if (ctl.round < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K_GRP2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_GRP3;
      end
   end

   assign t_sum = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_cur;

   // working variables
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (ctl.load) begin
         a_in = h_ff[0];
         b_in = h_ff[1];
         c_in = h_ff[2];
         d_in = h_ff[3];
         e_in = h_ff[4];
      end else if (ctl.step) begin
         a_in = t_sum;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   // chaining words: fold after a block, reload after a digest
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         h_in[i] = h_ff[i];
      end
      if (ctl.reinit) begin
         h_in[0] = INIT_H0;
         h_in[1] = INIT_H1;
         h_in[2] = INIT_H2;
         h_in[3] = INIT_H3;
         h_in[4] = INIT_H4;
      end else if (ctl.fold) begin
         h_in[0] = h_ff[0] + a_ff;
         h_in[1] = h_ff[1] + b_ff;
         h_in[2] = h_ff[2] + c_ff;
         h_in[3] = h_ff[3] + d_ff;
         h_in[4] = h_ff[4] + e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff[0] <= INIT_H0;
         h_ff[1] <= INIT_H1;
         h_ff[2] <= INIT_H2;
         h_ff[3] <= INIT_H3;
         h_ff[4] <= INIT_H4;
      end else begin
         for (int i = 0; i < 5; i++) begin
            h_ff[i] <= h_in[i];
         end
      end
   end

   // digest word select
   always_comb begin
      case (ctl.word_sel)
         3'd0:    digest_word = h_ff[0];
         3'd1:    digest_word = h_ff[1];
         3'd2:    digest_word = h_ff[2];
         3'd3:    digest_word = h_ff[3];
         default: digest_word = h_ff[4];
      endcase
   end

endmodule

### rtl/core/sha1_message_digest_unit.sv
// Flow: a byte item that does not fill a block is simply taken; one that fills it
//   starts the 80 rounds and a fold, all in the shared round datapath.
// End of message: padding bytes are pushed until the block is full (one byte a cycle),
//   then 80 rounds and a fold per padded block (one or two), then five digest words.
// Items are taken one at a time; no new item is taken until the unit is idle again.
// Reset (synchronous): chaining words to the initial values, counters cleared.
module sha1_message_digest_unit
   import sha1_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_digest_last
);

   state_type     state_ff, state_in;
   logic [5:0]    fill_ff, fill_in;
   logic [63:0]   total_ff, total_in;
   logic [6:0]    round_ff, round_in;
   logic [2:0]    word_ff, word_in;
   logic          pend_end_ff, pend_end_in;
   logic          mark_ff, mark_in;
   logic          len_ok_ff, len_ok_in;
   logic          len_done_ff, len_done_in;
   logic          rsp_take;
   logic [63:0]   bit_len;
   logic [7:0]    len_byte;
   logic [7:0]    pad_byte;
   logic [31:0]   w_cur;
   sched_ctl_type sched_ctl;
   round_ctl_type round_ctl;

   assign rsp_take = rsp_valid && !rsp_stall;

   // padding byte: mark, zeros, then the big-endian bit length in the last 8 slots
   assign bit_len  = {total_ff[60:0], 3'b000};
   assign len_byte = bit_len[{~fill_ff[2:0], 3'b000} +: 8];
   always_comb begin
      if (!mark_ff) begin
         pad_byte = PAD_BYTE;
      end else if (len_ok_ff && fill_ff >= LEN_OFFSET) begin
         pad_byte = len_byte;
      end else begin
         pad_byte = 8'h00;
      end
   end

   // state register and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         total_ff    <= '0;
         round_ff    <= '0;
         word_ff     <= '0;
         pend_end_ff <= 1'b0;
         mark_ff     <= 1'b0;
         len_ok_ff   <= 1'b0;
         len_done_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         total_ff    <= total_in;
         round_ff    <= round_in;
         word_ff     <= word_in;
         pend_end_ff <= pend_end_in;
         mark_ff     <= mark_in;
         len_ok_ff   <= len_ok_in;
         len_done_ff <= len_done_in;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      total_in    = total_ff;
      round_in    = round_ff;
      word_in     = word_ff;
      pend_end_in = pend_end_ff;
      mark_in     = mark_ff;
      len_ok_in   = len_ok_ff;
      len_done_in = len_done_ff;

      sched_ctl.push      = 1'b0;
      sched_ctl.push_byte = req_data_byte;
      sched_ctl.step      = 1'b0;

      round_ctl.load     = 1'b0;
      round_ctl.step     = 1'b0;
      round_ctl.round    = round_ff;
      round_ctl.fold     = 1'b0;
      round_ctl.reinit   = 1'b0;
      round_ctl.word_sel = word_ff;

      req_stall = 1'b1;
      rsp_valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               pend_end_in = req_end_of_message;
               mark_in     = 1'b0;
               len_ok_in   = 1'b0;
               len_done_in = 1'b0;
               if (req_byte_present) begin
                  sched_ctl.push = 1'b1;
                  fill_in        = fill_ff + 6'd1;
                  total_in       = total_ff + 64'd1;
               end
               if (req_byte_present && fill_ff == LAST_SLOT) begin
                  round_ctl.load = 1'b1;
                  round_in       = '0;
                  state_in       = ST_ROUND;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end

         ST_ROUND: begin
            sched_ctl.step = 1'b1;
            round_ctl.step = 1'b1;
            round_in       = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end

         ST_FOLD: begin
            round_ctl.fold = 1'b1;
            if (len_done_ff) begin
               word_in  = '0;
               state_in = ST_OUT;
            end else if (pend_end_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_PAD: begin
            sched_ctl.push      = 1'b1;
            sched_ctl.push_byte = pad_byte;
            fill_in             = fill_ff + 6'd1;
            mark_in             = 1'b1;
            if (fill_ff == LAST_SLOT || (!mark_ff && fill_ff < LEN_OFFSET)) begin
               len_ok_in = 1'b1;
            end
            if (fill_ff == LAST_SLOT) begin
               len_done_in    = mark_ff && len_ok_ff;
               round_ctl.load = 1'b1;
               round_in       = '0;
               state_in       = ST_ROUND;
            end
         end

         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               word_in = word_ff + 3'd1;
               if (word_ff == LAST_WORD) begin
                  round_ctl.reinit = 1'b1;
                  fill_in          = '0;
                  total_in         = '0;
                  pend_end_in      = 1'b0;
                  len_done_in      = 1'b0;
                  state_in         = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_digest_last = (word_ff == LAST_WORD);

   sha1_msg_sched u_sched (
      .clock (clock),
      .ctl   (sched_ctl),
      .w_cur (w_cur)
   );

   sha1_round_core u_round (
      .clock       (clock),
      .reset       (reset),
      .ctl         (round_ctl),
      .w_cur       (w_cur),
      .digest_word (rsp_digest_word)
   );

`ifndef ASSERT_OFF
   // no result is offered while the input side is open
   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("result offered while accepting items");

   // the digest is only read out after the final block has been folded
   a_out_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (fill_ff == '0))
      else $error("digest output with a partly filled block");

   // the round counter never runs past the last round
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (round_ff <= LAST_ROUND))
      else $error("round counter out of range");

   // taking the last word clears the length counter for the next message
   a_clear_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_digest_last) |=> (total_ff == '0) && (state_ff == ST_IDLE))
      else $error("length not cleared after digest");
`endif

endmodule

### dv/sha1_digest_checker.sv
// Checker for the SHA-1 digest unit: predicts digest words from accepted bytes and compares.
`timescale 1ns / 100ps

module sha1_digest_checker
   import sha1_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_digest_word,
   input  logic        rsp_digest_last,
   output int          fail_count,
   output int          words_pending,
   output int          words_checked
);

   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [31:0] word;
      logic        last;
   } digest_word_type;

   // Predicted hash state
   logic [31:0] chain_h [0:4];
   logic [7:0]  blk_bytes [0:63];
   logic [6:0]  blk_fill;
   logic [63:0] msg_len;

   digest_word_type digest_due [$];

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
      return (v << s) | (v >> (32 - s));
   endfunction

   task automatic reload_chain();
      chain_h[0] = INIT_H0;
      chain_h[1] = INIT_H1;
      chain_h[2] = INIT_H2;
      chain_h[3] = INIT_H3;
      chain_h[4] = INIT_H4;
      blk_fill   = '0;
      msg_len    = '0;
   endtask

   // 80-round compression of the held block into the chaining words
   task automatic compress_block();
      logic [31:0] w [0:79];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
         w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
      for (int i = 16; i < 80; i++)
         w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = K_GRP0;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = K_GRP1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_GRP2;
         end else begin
            f = b ^ c ^ d;
            k = K_GRP3;
         end
         t = rotl(a, 5) + f + e + k + w[i];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      chain_h[0] = chain_h[0] + a;
      chain_h[1] = chain_h[1] + b;
      chain_h[2] = chain_h[2] + c;
      chain_h[3] = chain_h[3] + d;
      chain_h[4] = chain_h[4] + e;
   endtask

   // Place one byte in the block; compress once 64 are held
   task automatic absorb_byte(input logic [7:0] v);
      blk_bytes[blk_fill[5:0]] = v;
      blk_fill = blk_fill + 7'd1;
      if (blk_fill >= 7'd64) begin
         compress_block();
         blk_fill = '0;
      end
   endtask

   // Padding, length field and the five digest words
   task automatic finish_message();
      logic [63:0]     bit_len;
      digest_word_type dw;
      bit_len = msg_len << 3;
      absorb_byte(PAD_BYTE);
      while (blk_fill != {1'b0, LEN_OFFSET})
         absorb_byte(8'h00);
      for (int i = 0; i < 8; i++)
         absorb_byte(bit_len[63 - 8*i -: 8]);
      for (int i = 0; i < 5; i++) begin
         dw.word = chain_h[i];
         dw.last = (i == LAST_WORD);
         digest_due.insert(digest_due.size(), dw);
      end
      reload_chain();
   endtask

   // Watch both channels on every rising edge
   always @(posedge clock) begin
      digest_word_type due;
      if (reset) begin
         reload_chain();
         digest_due.delete();
         fail_count    = 0;
         words_checked = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_byte_present) begin
               absorb_byte(req_data_byte);
               msg_len = msg_len + 64'd1;
            end
            if (req_end_of_message)
               finish_message();
         end
         if (rsp_valid && !rsp_stall) begin
            if (digest_due.size() == 0) begin
               if (fail_count < MAX_REPORTS)
                  $display("%0t: unexpected digest word %h last %b", $realtime,
                           rsp_digest_word, rsp_digest_last);
               fail_count++;
            end else begin
               due = digest_due.pop_front();
               words_checked++;
               if (rsp_digest_word !== due.word || rsp_digest_last !== due.last) begin
                  if (fail_count < MAX_REPORTS)
                     $display("%0t: digest mismatch: expected %h last %b, got %h last %b",
                              $realtime, due.word, due.last, rsp_digest_word,
                              rsp_digest_last);
                  fail_count++;
               end
            end
         end
      end
      words_pending = digest_due.size();
   end

endmodule

### dv/tb_sha1_message_digest_unit.sv
// Top of the SHA-1 digest unit testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module tb_sha1_message_digest_unit;

   localparam int  HOLD_CYCLES = 400;
   localparam int  NOISE_PCT   = 2;
   localparam int  PHASE_BYTES = 6;
   localparam int  DRAIN_TAIL  = 200;
   localparam real TIMEOUT_NS  = 2_000_000.0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_present = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic        rsp_digest_last;

   int fail_count;
   int words_pending;
   int words_checked;

   // Idle/stall mix, set per phase
   int  idle_pct  = 0;
   int  stall_pct = 0;
   logic hold_start = 1'b0;

   int items_sent = 0;
   int bytes_sent = 0;
   int msgs_sent  = 0;

   always #5 clock = ~clock;

   sha1_message_digest_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_digest_last    (rsp_digest_last)
   );

   sha1_digest_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_digest_last    (rsp_digest_last),
      .fail_count         (fail_count),
      .words_pending      (words_pending),
      .words_checked      (words_checked)
   );

   // Receiver stall; a requested hold-off is counted down here
   int   hold_left = 0;
   logic hold_start_q = 1'b0;
   always @(negedge clock) begin
      if (hold_start && !hold_start_q)
         hold_left = HOLD_CYCLES;
      hold_start_q = hold_start;
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offer one item after a random gap; return at the falling edge after it is taken
   task automatic send_item(input logic [7:0] d, input logic present, input logic eom);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= d;
      req_byte_present   <= present;
      req_end_of_message <= eom;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
      items_sent++;
      if (present)
         bytes_sent++;
      if (eom)
         msgs_sent++;
   endtask

   // Random message of n bytes with scattered empty items; ends on the last byte or alone
   task automatic send_message(input int n);
      logic eom_alone;
      eom_alone = (n == 0) ? 1'b1 : 1'($urandom_range(1));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < NOISE_PCT)
            send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, (i == n - 1) && !eom_alone);
      end
      if (eom_alone)
         send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (words_pending != 0)
         @(negedge clock);
   endtask

   initial begin
      int phase_bytes;
      int long_len;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed: empty message, "abc", empty items, extremes, end without a byte
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b1);
      wait_drained();

      // Random phases; the first opens with a long message that fills one block
      // from bytes and ends the next one past the length slot
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
               long_len  = $urandom_range(120, 127);
            end
            1: begin idle_pct = 62; stall_pct = 0;  long_len = 0; end
            2: begin idle_pct = 0;  stall_pct = 62; long_len = 0; end
            default: begin
               idle_pct  = 31;
               stall_pct = 31;
               long_len  = 0;
            end
         endcase
         phase_bytes = long_len;
         if (long_len != 0)
            send_message(long_len);
         while (phase_bytes < PHASE_BYTES) begin
            long_len = $urandom_range(0, 6);
            send_message(long_len);
            phase_bytes += long_len;
         end
         wait_drained();
      end

      // Long output hold while short messages keep coming, so the input backs up
      idle_pct  = 0;
      stall_pct = 0;
      hold_start <= 1'b1;
      @(negedge clock);
      for (int i = 0; i < 4; i++)
         send_message(2);

      // Wind down: no more input, let every digest word drain
      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);

      $display("summary: %0d messages, %0d bytes in %0d items, four idle/stall mixes",
               msgs_sent, bytes_sent, items_sent);
      $display("summary: %0d digest words compared, incl. one long output hold-off",
               words_checked);
      if (fail_count == 0 && words_pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule
